@@ src/date_weekday_and_days_remaining_defines.svh @@
// Assertion macros for the date weekday and days-remaining block.
`ifndef DATE_WEEKDAY_AND_DAYS_REMAINING_DEFINES_SVH
`define DATE_WEEKDAY_AND_DAYS_REMAINING_DEFINES_SVH
`ifndef SYNTHESIS
`define DWDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DWDR_ASSERT_NEVER(lbl, cond, msg) \
  `DWDR_ASSERT(lbl, !(cond), msg)
`else
`define DWDR_ASSERT(lbl, prop, msg)
`define DWDR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ src/dwdr_pkg.sv @@
// Shared types, constants and month tables for the date weekday block.
package dwdr_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned YY_W    = 15;
  localparam int unsigned Q_W     = 8;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned DOW_W   = 3;
  localparam int unsigned DTEM_W  = 5;
  localparam int unsigned DTEY_W  = 9;
  localparam int unsigned MASK_W  = 7;
  localparam int unsigned SHIFT_W = 6;

  localparam logic [MASK_W-1:0]  WEEKEND_MASK_RESET = 7'h60;
  localparam logic [YY_W-1:0]    YEAR_BIAS          = 15'd400;
  // floor(x / 100) = (x * DIV100_K) >> DIV100_SH, exact for x below 2**15
  localparam logic [YY_W-1:0]    DIV100_K           = 15'd20972;
  localparam int unsigned        DIV100_SH          = 21;
  localparam int unsigned        PROD_W             = 2 * YY_W;
  localparam logic [YEAR_W-1:0]  CENTURY            = 14'd100;
  localparam logic [DOW_W-1:0]   DOW_SATURDAY       = 3'd6;
  localparam logic [DOY_W-1:0]   YEAR_LEN_COMMON    = 9'd365;
  localparam logic [MONTH_W-1:0] MONTH_MARCH        = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_FEBRUARY     = 4'd2;

  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [YY_W-1:0]    yy;
    logic [DAY_W-1:0]   d;
    logic [SHIFT_W-1:0] shift_term;
    logic [DTEM_W-1:0]  mlen_base;
    logic               is_feb;
    logic [DOY_W-1:0]   cum_base;
    logic               after_feb;
  } s1_t;

  typedef struct packed {
    logic [YEAR_W-1:0] y;
    logic [Q_W-1:0]    qy;
    logic [Q_W-1:0]    qyy;
    logic [YY_W-1:0]   part;
    logic [DAY_W-1:0]  d;
    logic [DTEM_W-1:0] mlen_base;
    logic              is_feb;
    logic [DOY_W-1:0]  doy_part;
    logic              after_feb;
  } s2_t;

  typedef struct packed {
    logic [YY_W-1:0]   sum;
    logic              leap;
    logic [DAY_W-1:0]  d;
    logic [DTEM_W-1:0] mlen_base;
    logic              is_feb;
    logic [DOY_W-1:0]  doy_part;
    logic              after_feb;
  } s3_t;

  typedef struct packed {
    logic [DTEY_W-1:0] dtey;
    logic [DTEM_W-1:0] dtem;
    logic [DOW_W-1:0]  dtew;
    logic              bd;
    logic              wk;
    logic              eow;
    logic [DOW_W-1:0]  dow;
  } res_t;

  // floor(31 * shifted_month / 12), shifted month 10..12 for months 0..2
  function automatic logic [SHIFT_W-1:0] month_shift_term(input logic [MONTH_W-1:0] mo);
    logic [SHIFT_W-1:0] t;
    case (mo)
      4'd0:    t = 6'd25;
      4'd1:    t = 6'd28;
      4'd2:    t = 6'd31;
      4'd3:    t = 6'd2;
      4'd4:    t = 6'd5;
      4'd5:    t = 6'd7;
      4'd6:    t = 6'd10;
      4'd7:    t = 6'd12;
      4'd8:    t = 6'd15;
      4'd9:    t = 6'd18;
      4'd10:   t = 6'd20;
      4'd11:   t = 6'd23;
      4'd12:   t = 6'd25;
      4'd13:   t = 6'd28;
      4'd14:   t = 6'd31;
      default: t = 6'd33;
    endcase
    return t;
  endfunction

  // Month length in a common year, zero outside 1..12
  function automatic logic [DTEM_W-1:0] month_len_base(input logic [MONTH_W-1:0] mo);
    logic [DTEM_W-1:0] l;
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

  // Days of the earlier months in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] mo);
    logic [DOY_W-1:0] c;
    case (mo)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      4'd12:      c = 9'd334;
      default:    c = 9'd365;
    endcase
    return c;
  endfunction

endpackage

@@ src/dwdr_front.sv @@
// Stage 1: biased year and month table lookups.
module dwdr_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [dwdr_pkg::YEAR_W-1:0]  year_i,
  input  logic [dwdr_pkg::MONTH_W-1:0] month_i,
  input  logic [dwdr_pkg::DAY_W-1:0]   day_i,
  output dwdr_pkg::s1_t                 s1_o
);
  import dwdr_pkg::*;

  s1_t s1_d, s1_q;
  logic early;

  always_comb begin
    // January, February (and month zero) count in the previous year
    early           = (month_i < MONTH_MARCH);
    s1_d.y          = year_i;
    s1_d.yy         = YY_W'(year_i) + YEAR_BIAS - YY_W'(early);
    s1_d.d          = day_i;
    s1_d.shift_term = month_shift_term(month_i);
    s1_d.mlen_base  = month_len_base(month_i);
    s1_d.is_feb     = (month_i == MONTH_FEBRUARY);
    s1_d.cum_base   = days_before(month_i);
    s1_d.after_feb  = !early;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;
endmodule

@@ src/dwdr_quot.sv @@
// Stage 2: divide both years by 100 with reciprocal multiplies, and start the weekday sum and the day of year.
module dwdr_quot (
  input  logic          clk_i,
  input  logic          en_i,
  input  dwdr_pkg::s1_t s1_i,
  output dwdr_pkg::s2_t s2_o
);
  import dwdr_pkg::*;

  s2_t s2_d, s2_q;
  logic [PROD_W-1:0] prod_y, prod_yy;

  always_comb begin
    prod_y          = PROD_W'(s1_i.y) * PROD_W'(DIV100_K);
    prod_yy         = PROD_W'(s1_i.yy) * PROD_W'(DIV100_K);
    s2_d.y          = s1_i.y;
    s2_d.qy         = Q_W'(prod_y >> DIV100_SH);
    s2_d.qyy        = Q_W'(prod_yy >> DIV100_SH);
    s2_d.part       = YY_W'(s1_i.d) + s1_i.yy + (s1_i.yy >> 2) + YY_W'(s1_i.shift_term);
    s2_d.d          = s1_i.d;
    s2_d.mlen_base  = s1_i.mlen_base;
    s2_d.is_feb     = s1_i.is_feb;
    s2_d.doy_part   = DOY_W'(s1_i.d) + s1_i.cum_base;
    s2_d.after_feb  = s1_i.after_feb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;
endmodule

@@ src/dwdr_leap.sv @@
// Stage 3: leap-year test and the weekday sum.
module dwdr_leap (
  input  logic          clk_i,
  input  logic          en_i,
  input  dwdr_pkg::s2_t s2_i,
  output dwdr_pkg::s3_t s3_o
);
  import dwdr_pkg::*;

  s3_t s3_d, s3_q;
  logic [YEAR_W-1:0] rem100;

  always_comb begin
    rem100         = s2_i.y - YEAR_W'(YEAR_W'(s2_i.qy) * CENTURY);
    // Divisible by 4, and not a century unless also by 400
    s3_d.leap      = (s2_i.y[1:0] == 2'b00) && ((rem100 != '0) || (s2_i.qy[1:0] == 2'b00));
    s3_d.sum       = s2_i.part + YY_W'(s2_i.qyy >> 2) - YY_W'(s2_i.qyy);
    s3_d.d         = s2_i.d;
    s3_d.mlen_base = s2_i.mlen_base;
    s3_d.is_feb    = s2_i.is_feb;
    s3_d.doy_part  = s2_i.doy_part;
    s3_d.after_feb = s2_i.after_feb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;
endmodule

@@ src/dwdr_finish.sv @@
// Stage 4: modulo 7, flags and remaining-day counts into the output register.
module dwdr_finish (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [dwdr_pkg::MASK_W-1:0] mask_i,
  input  dwdr_pkg::s3_t                s3_i,
  output dwdr_pkg::res_t               res_o
);
  import dwdr_pkg::*;

  res_t res_d, res_q;
  logic [SHIFT_W-1:0] fold1;
  logic [3:0]         fold2;
  logic [DOW_W-1:0]   dow;
  logic [DTEM_W-1:0]  mlen;
  logic [DOY_W-1:0]   ylen, doy;

  always_comb begin
    // 8 = 1 mod 7: add octal digits, twice, then one conditional subtract
    fold1 = SHIFT_W'(s3_i.sum[2:0]) + SHIFT_W'(s3_i.sum[5:3]) + SHIFT_W'(s3_i.sum[8:6])
          + SHIFT_W'(s3_i.sum[11:9]) + SHIFT_W'(s3_i.sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    dow   = (fold2 >= 4'd7) ? DOW_W'(fold2 - 4'd7) : fold2[DOW_W-1:0];

    mlen  = s3_i.mlen_base + DTEM_W'(s3_i.is_feb & s3_i.leap);
    ylen  = YEAR_LEN_COMMON + DOY_W'(s3_i.leap);
    doy   = s3_i.doy_part + DOY_W'(s3_i.after_feb & s3_i.leap);

    res_d.dow  = dow;
    res_d.eow  = (dow == DOW_SATURDAY);
    res_d.wk   = mask_i[dow];
    res_d.bd   = !mask_i[dow];
    res_d.dtew = DOW_SATURDAY - dow;
    res_d.dtem = (mlen > s3_i.d) ? (mlen - s3_i.d) : '0;
    res_d.dtey = (ylen > doy) ? (ylen - doy) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule

@@ src/date_weekday_and_days_remaining.sv @@
// Gregorian weekday and days-remaining block, four register stages deep.
// An accepted input beat passes the front, quotient, leap and finish registers in order to its output beat.
// Throughput: one beat per cycle; all stages hold together while the output
// beat waits, so a stall drops and repeats nothing.
// Reset: valid bits clear and the weekend mask returns to Friday and Saturday.
`include "date_weekday_and_days_remaining_defines.svh"
module date_weekday_and_days_remaining (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // year[13:0], month[17:14], day[22:18], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // day_of_week[2:0], is_end_of_week[3], is_weekend[4],
                                      // is_business_day[5], days_to_end_of_week[8:6],
                                      // days_to_end_of_month[13:9],
                                      // days_to_end_of_year[22:14], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i      // weekend_day_mask
);
  import dwdr_pkg::*;

  localparam int unsigned NSTAGE = 4;

  logic [MASK_W-1:0] mask_d, mask_q;
  logic [NSTAGE-1:0] vld_d, vld_q;
  logic              advance;
  s1_t               s1;
  s2_t               s2;
  s3_t               s3;
  res_t              res;

  // Mask register: written whenever a config beat arrives
  assign cfg_ready_o = 1'b1;
  assign mask_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= WEEKEND_MASK_RESET;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Advance the whole pipe unless a finished beat sits unclaimed at the output
  assign advance       = !vld_q[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = advance;
  assign vld_d         = advance ? {vld_q[NSTAGE-2:0], s_axis_tvalid} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  dwdr_front u_front (
    .clk_i   (clk_i),
    .en_i    (advance),
    .year_i  (s_axis_tdata[13:0]),
    .month_i (s_axis_tdata[17:14]),
    .day_i   (s_axis_tdata[22:18]),
    .s1_o    (s1)
  );

  dwdr_quot u_quot (
    .clk_i (clk_i),
    .en_i  (advance),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  dwdr_leap u_leap (
    .clk_i (clk_i),
    .en_i  (advance),
    .s2_i  (s2),
    .s3_o  (s3)
  );

  dwdr_finish u_finish (
    .clk_i  (clk_i),
    .en_i   (advance),
    .mask_i (mask_q),
    .s3_i   (s3),
    .res_o  (res)
  );

  assign m_axis_tvalid = vld_q[NSTAGE-1];
  assign m_axis_tdata  = {1'b0, res.dtey, res.dtem, res.dtew, res.bd, res.wk, res.eow, res.dow};

  // Checks on the datapath and the valid chain
  `DWDR_ASSERT(a_dow_range, m_axis_tvalid |-> (res.dow <= DOW_SATURDAY),
    "weekday out of range")
  `DWDR_ASSERT(a_week_fields, m_axis_tvalid |-> ((res.dtew == DOW_SATURDAY - res.dow)
    && (res.eow == (res.dow == DOW_SATURDAY)) && (res.bd != res.wk)),
    "week fields disagree with weekday")
  `DWDR_ASSERT(a_year_ge_month, m_axis_tvalid |-> (DOY_W'(res.dtem) <= res.dtey),
    "fewer days left in year than in month")
  `DWDR_ASSERT(a_chain_moves, (advance && vld_q[NSTAGE-2]) |=> vld_q[NSTAGE-1],
    "beat lost between last two stages")
endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the Gregorian weekday and days-remaining block with its own date predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dwdr_pkg::*;

  // Give up well past the slowest legal run: about 600 beats, each with a full sender gap,
  // a full receiver stall and the pipeline, plus the long receiver hold-off.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;

  // Input beat, lowest bit first: year, month, day, zero pad.
  typedef struct packed {
    logic               pad;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // Output beat, lowest bit first: weekday, Saturday flag, weekend flag, business-day
  // flag, days to end of week, days to end of month, days to end of year, zero pad.
  typedef struct packed {
    logic              pad;
    logic [DTEY_W-1:0] to_year_end;
    logic [DTEM_W-1:0] to_month_end;
    logic [DOW_W-1:0]  to_week_end;
    logic              business;
    logic              weekend;
    logic              saturday;
    logic [DOW_W-1:0]  weekday;
  } calendar_t;

  typedef struct {
    date_t     date;
    calendar_t cal;
  } pending_date_t;

  // Scoreboard: predicts the calendar beat for every accepted date and checks the
  // output beats against those predictions in order.
  class calendar_scoreboard;
    logic [MASK_W-1:0] weekend_mask;
    pending_date_t     expected_q[$];
    int unsigned       errors;

    function new();
      weekend_mask = WEEKEND_MASK_RESET;
      errors       = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned days_in_month(int unsigned y, int unsigned mo);
      case (mo)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return is_leap(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    function calendar_t predict(date_t dt);
      calendar_t        c;
      int unsigned      y, mo, d, early, yy, mm, dow, mlen, ylen, doy;
      logic [DOW_W-1:0] dow_f;
      y  = 32'(dt.year);
      mo = 32'(dt.month);
      d  = 32'(dt.day);
      // Shift January and February to the end of the previous year; bias the year by
      // one whole 400-year cycle so nothing underflows.
      early = (mo <= 2) ? 1 : 0;
      yy    = y + 400 - early;
      mm    = mo + 12 * early - 2;
      dow   = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      mlen  = days_in_month(y, mo);
      ylen  = is_leap(y) ? 366 : 365;
      doy   = d;
      for (int unsigned i = 1; i < mo; i++) doy += days_in_month(y, i);
      dow_f          = DOW_W'(dow);
      c              = '0;
      c.weekday      = dow_f;
      c.saturday     = (dow_f == DOW_SATURDAY);
      c.weekend      = weekend_mask[dow_f];
      c.business     = !weekend_mask[dow_f];
      c.to_week_end  = DOW_SATURDAY - dow_f;
      c.to_month_end = DTEM_W'((mlen > d) ? mlen - d : 0);
      c.to_year_end  = DTEY_W'((ylen > doy) ? ylen - doy : 0);
      return c;
    endfunction

    function void note_date(date_t dt);
      pending_date_t p;
      p.date = dt;
      p.cal  = predict(dt);
      expected_q.push_back(p);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want, date_t dt);
      if (got !== want)
        report($sformatf("%0d-%0d-%0d %s: got %0d, want %0d",
                         dt.year, dt.month, dt.day, name, got, want));
    endtask

    task check_calendar(calendar_t got);
      pending_date_t p;
      if (expected_q.size() == 0) begin
        report($sformatf("output beat %h with no date pending", got));
        return;
      end
      p = expected_q.pop_front();
      check_field("day_of_week", 16'(got.weekday), 16'(p.cal.weekday), p.date);
      check_field("is_end_of_week", 16'(got.saturday), 16'(p.cal.saturday), p.date);
      check_field("is_weekend", 16'(got.weekend), 16'(p.cal.weekend), p.date);
      check_field("is_business_day", 16'(got.business), 16'(p.cal.business), p.date);
      check_field("days_to_end_of_week", 16'(got.to_week_end), 16'(p.cal.to_week_end),
                  p.date);
      check_field("days_to_end_of_month", 16'(got.to_month_end), 16'(p.cal.to_month_end),
                  p.date);
      check_field("days_to_end_of_year", 16'(got.to_year_end), 16'(p.cal.to_year_end),
                  p.date);
    endtask
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [MASK_W-1:0] cfg_data_i    = '0;

  calendar_scoreboard sb = new();

  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left  = 0;
  int unsigned rx_stall_left = 0;
  int unsigned cycle_count   = 0;

  date_weekday_and_days_remaining i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drive the output ready: a requested long hold-off first, then random stall bursts.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready = 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready = 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 14) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Check every output beat taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_calendar(m_axis_tdata);
  end

  function automatic date_t date_of(int unsigned y, int unsigned mo, int unsigned d);
    date_t dt;
    dt       = '0;
    dt.year  = YEAR_W'(y);
    dt.month = MONTH_W'(mo);
    dt.day   = DAY_W'(d);
    return dt;
  endfunction

  // Mostly real dates; some with days past the month end; the rest any field value.
  function automatic date_t random_date();
    int unsigned pick, y, mo;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      y  = $urandom_range(1, 9999);
      mo = $urandom_range(1, 12);
      if (pick < 70) return date_of(y, mo, $urandom_range(1, sb.days_in_month(y, mo)));
      return date_of(y, mo, $urandom_range(0, 31));
    end
    return date_of($urandom_range(0, (1 << YEAR_W) - 1), $urandom_range(0, 15),
                   $urandom_range(0, 31));
  endfunction

  // Offer one date beat, maybe after an idle burst, and hold it until taken.
  task automatic send_date(input date_t dt);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = dt;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_date(dt);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_date(random_date());
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_weekend_mask(input logic [MASK_W-1:0] mask);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.weekend_mask = mask;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed dates under the reset mask (Friday and Saturday).
    send_date(date_of(1, 1, 1));
    send_date(date_of(9999, 12, 31));
    send_date(date_of(0, 1, 1));          // year zero, counted as leap
    send_date(date_of(16383, 15, 31));    // every field bit high
    send_date(date_of(0, 0, 0));          // every input bit low
    send_date(date_of(2000, 2, 29));      // leap by the 400 rule
    send_date(date_of(1900, 2, 29));      // not leap by the 100 rule, day past month end
    send_date(date_of(2024, 2, 29));
    send_date(date_of(2024, 12, 31));
    send_date(date_of(2023, 12, 31));
    send_date(date_of(2024, 3, 1));
    send_date(date_of(2023, 0, 15));      // month zero
    send_date(date_of(2023, 13, 5));      // months past December
    send_date(date_of(2023, 14, 0));
    send_date(date_of(2024, 15, 31));
    send_date(date_of(2023, 4, 31));      // day past month end
    send_date(date_of(2023, 6, 0));       // day zero
    send_date(date_of(2023, 1, 0));
    send_date(date_of(8191, 7, 16));
    send_date(date_of(2023, 10, 21));     // a Saturday
    send_date(date_of(2023, 10, 22));     // a Sunday
    send_date(date_of(2023, 10, 20));     // a Friday
    send_date(date_of(400, 2, 29));
    drain();

    // No weekend days.
    write_weekend_mask('0);
    send_random(120);

    // All weekend days; hold the output off while back-to-back beats fill the pipeline.
    drain();
    write_weekend_mask('1);
    tx_idle_on  = 1'b0;
    rx_hold_req = 1'b1;
    send_random(30);
    tx_idle_on = 1'b1;
    send_random(60);
    // Pause the sender until every result is out, then carry on.
    drain();
    send_random(40);

    // A random mask, idling switched on and off in stretches.
    drain();
    write_weekend_mask(MASK_W'($urandom_range(1, 126)));
    repeat (3) begin
      tx_idle_on = 1'($urandom_range(0, 1));
      rx_idle_on = 1'($urandom_range(0, 1));
      send_random(40);
    end

    // Last stretch: another mask, full rate on both sides.
    drain();
    write_weekend_mask(MASK_W'($urandom_range(0, 127)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(140);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
